### rtl/equatorial_horizontal_transform_macros.svh
// assertion macros shared by the equatorial / horizontal transform
`ifndef EQUATORIAL_HORIZONTAL_TRANSFORM_MACROS_SVH
`define EQUATORIAL_HORIZONTAL_TRANSFORM_MACROS_SVH

// same-cycle implication, quiet during reset
`define EHT_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("eht assertion failed");

// next-cycle implication, quiet during reset
`define EHT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("eht assertion failed");

`endif

### rtl/eht_pkg.sv
// shared constants, types and arctangent table of the coordinate transform
package eht_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int ANGLE_W       = 32;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES);
  localparam int XY_W          = 36;
  localparam int Z_W           = ANGLE_W + 2;
  localparam int AMP_W         = 34;
  localparam int MAG_W         = 32;

  localparam int ROT_LAT  = CORDIC_STAGES + 2;
  localparam int MUL_LAT  = 2;
  localparam int SIDE_LEN = 3 * ROT_LAT + 3 * MUL_LAT + 1;
  localparam int POLE_LEN = 2 * ROT_LAT + MUL_LAT;
  localparam int HOLD_LEN = ROT_LAT + MUL_LAT;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd1 << (ANGLE_W - 2));
  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(64'd1 << (ANGLE_W - 1));
  localparam logic signed [AMP_W-1:0] GAIN_Q30   = AMP_W'(652032874);

  // sidereal time: s * 2^32 = s * 49710 * 86400 + s * 23296
  localparam logic [15:0] LST_WHOLE   = 16'd49710;
  localparam logic [14:0] LST_REM     = 15'd23296;
  localparam logic [31:0] LST_HALFDAY = 32'd43200;
  localparam logic [25:0] LST_RECIP   = 26'd50903317;  // ceil(2^35 / 675)
  localparam int          LST_SHIFT   = 35;

  localparam logic CMD_EQ_TO_HOR = 1'b0;
  localparam logic CMD_HOR_TO_EQ = 1'b1;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  typedef struct packed {
    logic              cmd;
    logic [ANGLE_W-1:0] lst;
  } side_t;

  // atan(2^-i) in turns, 2^32 = one turn
  function automatic logic [ANGLE_W-1:0] atan_turns(input logic [STAGE_W-1:0] i);
    logic [ANGLE_W-1:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/equatorial_horizontal_transform.sv
// top level of the equatorial / horizontal coordinate transform
// One sky position per item. command 0 turns right ascension and declination
// into azimuth and elevation, command 1 goes the other way, both using the
// local sidereal time and the site latitude.
// Input channel: in_valid / in_stall with the item fields; output channel:
// out_valid / out_stall with out_lon, out_lat and pole_flag.
// Throughput: one item per cycle while in_stall is low. The datapath is a fixed
// pipeline: registered sidereal-time arithmetic, three parallel 34-stage
// cordic rotation chains, chained q30 products, a sum stage, a 34-stage
// vectoring chain for azimuth or hour angle, a gain product, a second
// vectoring chain for elevation or declination and a final stage.
// When out_stall holds the output, the pipeline still moves one more result
// into a skid register, then freezes and raises in_stall until the skid
// empties. Nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; no result is pending after.
`include "equatorial_horizontal_transform_macros.svh"

module equatorial_horizontal_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [31:0]        in_lon,
  input  logic signed [31:0] in_lat,
  input  logic [16:0]        sidereal_seconds,
  input  logic signed [31:0] site_latitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_lon,
  output logic signed [31:0] out_lat,
  output logic               pole_flag
);
  import eht_pkg::*;

  logic en;
  logic accept;
  logic take;

  // sidereal time front end
  logic                v_s1, v_s2, v_s3;
  logic                cmd_s1, cmd_s2, cmd_s3;
  logic [ANGLE_W-1:0]  lon_s1, lon_s2, lon_s3;
  logic [ANGLE_W-1:0]  lat_s1, lat_s2, lat_s3;
  logic [ANGLE_W-1:0]  site_s1, site_s2, site_s3;
  logic [31:0]         rem_s1;
  logic [31:0]         whole_s1, whole_s2;
  logic [50:0]         quot_s2;
  logic [ANGLE_W-1:0]  lst_s3;
  logic [ANGLE_W-1:0]  first_ang;

  cordic_vec_t rot1_in, rot2_in, rot3_in;
  cordic_vec_t rot1_out, rot2_out, rot3_out;

  logic signed [AMP_W-1:0] c1, s1, c2, s2, cp, sp;
  logic signed [AMP_W-1:0] t_m, s2cp_m, s2sp_m, s1c2_m, tsp_m, tcp_m;
  logic signed [AMP_W-1:0] cp_d [MUL_LAT];
  logic signed [AMP_W-1:0] sp_d [MUL_LAT];
  logic signed [AMP_W-1:0] s2cp_d [MUL_LAT];
  logic signed [AMP_W-1:0] s2sp_d [MUL_LAT];
  logic signed [AMP_W-1:0] s1c2_d [MUL_LAT];

  logic signed [AMP_W-1:0] x_sum, y_sum, z_sum;
  logic signed [AMP_W-1:0] hx, hy, hz;
  logic                    pole;

  cordic_vec_t vec1_in, vec1_out, vec2_in, vec2_out;
  logic signed [AMP_W-1:0] mag_r;
  logic signed [AMP_W-1:0] r_forced;

  logic                    pole_d [POLE_LEN];
  logic signed [AMP_W-1:0] z_d [HOLD_LEN];
  logic [ANGLE_W-1:0]      lon_d [HOLD_LEN];
  side_t                   side_d [SIDE_LEN];
  logic [SIDE_LEN-1:0]     v_line;

  logic [ANGLE_W-1:0] lon_v;
  logic [ANGLE_W-1:0] lon_fin;

  logic               tail_v;
  logic [31:0]        tail_lon;
  logic [31:0]        tail_lat;
  logic               tail_pole;
  logic               skid_v;
  logic [31:0]        skid_lon;
  logic [31:0]        skid_lat;
  logic               skid_pole;

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  // ---- sidereal seconds to turns, by reciprocal multiply ----
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_s1   <= command;
      lon_s1   <= in_lon;
      lat_s1   <= in_lat;
      site_s1  <= site_latitude;
      rem_s1   <= 32'(sidereal_seconds) * 32'(LST_REM) + LST_HALFDAY;
      whole_s1 <= 32'(sidereal_seconds) * 32'(LST_WHOLE);

      cmd_s2   <= cmd_s1;
      lon_s2   <= lon_s1;
      lat_s2   <= lat_s1;
      site_s2  <= site_s1;
      whole_s2 <= whole_s1;
      // divide by 86400 as shift by 7 then divide by 675
      quot_s2  <= rem_s1[31:7] * LST_RECIP;

      cmd_s3   <= cmd_s2;
      lon_s3   <= lon_s2;
      lat_s3   <= lat_s2;
      site_s3  <= site_s2;
      lst_s3   <= whole_s2 + 32'(quot_s2[50:LST_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
      v_s3 <= 1'b0;
    end else if (en) begin
      v_s1 <= accept;
      v_s2 <= v_s1;
      v_s3 <= v_s2;
    end
  end

  // ---- three rotations: hour angle or azimuth, latitude, site latitude ----
  assign first_ang = (cmd_s3 == CMD_HOR_TO_EQ) ? lon_s3 : lst_s3 - lon_s3;

  always_comb begin
    rot1_in.x = XY_W'(GAIN_Q30);
    rot1_in.y = '0;
    rot1_in.z = Z_W'(signed'(first_ang));
    rot2_in   = rot1_in;
    rot2_in.z = Z_W'(signed'(lat_s3));
    rot3_in   = rot1_in;
    rot3_in.z = Z_W'(signed'(site_s3));
  end

  eht_cordic_chain u_rot1 (
    .clk (clk), .en (en), .mode (CORDIC_ROTATE), .d_in (rot1_in), .d_out (rot1_out)
  );
  eht_cordic_chain u_rot2 (
    .clk (clk), .en (en), .mode (CORDIC_ROTATE), .d_in (rot2_in), .d_out (rot2_out)
  );
  eht_cordic_chain u_rot3 (
    .clk (clk), .en (en), .mode (CORDIC_ROTATE), .d_in (rot3_in), .d_out (rot3_out)
  );

  assign c1 = AMP_W'(rot1_out.x);
  assign s1 = AMP_W'(rot1_out.y);
  assign c2 = AMP_W'(rot2_out.x);
  assign s2 = AMP_W'(rot2_out.y);
  assign cp = AMP_W'(rot3_out.x);
  assign sp = AMP_W'(rot3_out.y);

  // ---- spherical products ----
  eht_mulq u_m_t    (.clk (clk), .en (en), .a (c1), .b (c2), .p (t_m));
  eht_mulq u_m_s2cp (.clk (clk), .en (en), .a (s2), .b (cp), .p (s2cp_m));
  eht_mulq u_m_s2sp (.clk (clk), .en (en), .a (s2), .b (sp), .p (s2sp_m));
  eht_mulq u_m_s1c2 (.clk (clk), .en (en), .a (s1), .b (c2), .p (s1c2_m));

  always_ff @(posedge clk) begin
    if (en) begin
      cp_d[0]   <= cp;
      sp_d[0]   <= sp;
      s2cp_d[0] <= s2cp_m;
      s2sp_d[0] <= s2sp_m;
      s1c2_d[0] <= s1c2_m;
      for (int k = 1; k < MUL_LAT; k++) begin
        cp_d[k]   <= cp_d[k-1];
        sp_d[k]   <= sp_d[k-1];
        s2cp_d[k] <= s2cp_d[k-1];
        s2sp_d[k] <= s2sp_d[k-1];
        s1c2_d[k] <= s1c2_d[k-1];
      end
    end
  end

  eht_mulq u_m_tsp (.clk (clk), .en (en), .a (t_m), .b (sp_d[MUL_LAT-1]), .p (tsp_m));
  eht_mulq u_m_tcp (.clk (clk), .en (en), .a (t_m), .b (cp_d[MUL_LAT-1]), .p (tcp_m));

  always_comb begin
    x_sum = s2cp_d[MUL_LAT-1] - tsp_m;
    y_sum = -s1c2_d[MUL_LAT-1];
    z_sum = tcp_m + s2sp_d[MUL_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx   <= x_sum;
      hy   <= y_sum;
      hz   <= z_sum;
      pole <= (x_sum == '0) && (y_sum == '0);
    end
  end

  // ---- azimuth / hour angle and horizontal magnitude ----
  always_comb begin
    vec1_in.x = XY_W'(hx);
    vec1_in.y = XY_W'(hy);
    vec1_in.z = '0;
  end

  eht_cordic_chain u_vec1 (
    .clk (clk), .en (en), .mode (CORDIC_VECTOR), .d_in (vec1_in), .d_out (vec1_out)
  );

  eht_mulq u_m_gain (
    .clk (clk), .en (en), .a (AMP_W'(vec1_out.x)), .b (GAIN_Q30), .p (mag_r)
  );

  assign r_forced = pole_d[HOLD_LEN-1] ? '0 : mag_r;

  always_comb begin
    vec2_in.x = XY_W'(r_forced);
    vec2_in.y = XY_W'(z_d[HOLD_LEN-1]);
    vec2_in.z = '0;
  end

  eht_cordic_chain u_vec2 (
    .clk (clk), .en (en), .mode (CORDIC_VECTOR), .d_in (vec2_in), .d_out (vec2_out)
  );

  // ---- alignment lines ----
  always_ff @(posedge clk) begin
    if (en) begin
      pole_d[0] <= pole;
      for (int k = 1; k < POLE_LEN; k++) begin
        pole_d[k] <= pole_d[k-1];
      end
      z_d[0]   <= hz;
      lon_d[0] <= vec1_out.z[ANGLE_W-1:0];
      for (int k = 1; k < HOLD_LEN; k++) begin
        z_d[k]   <= z_d[k-1];
        lon_d[k] <= lon_d[k-1];
      end
      side_d[0] <= '{cmd: cmd_s3, lst: lst_s3};
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_line <= '0;
    end else if (en) begin
      v_line <= {v_line[SIDE_LEN-2:0], v_s3};
    end
  end

  // ---- final stage ----
  always_comb begin
    lon_v   = pole_d[POLE_LEN-1] ? '0 : lon_d[HOLD_LEN-1];
    lon_fin = (side_d[SIDE_LEN-1].cmd == CMD_HOR_TO_EQ)
              ? side_d[SIDE_LEN-1].lst - lon_v : lon_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_lon  <= lon_fin;
      tail_lat  <= vec2_out.z[ANGLE_W-1:0];
      tail_pole <= pole_d[POLE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_v <= 1'b0;
    end else if (en) begin
      tail_v <= v_line[SIDE_LEN-1];
    end
  end

  // ---- output register with skid ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= en && tail_v;
      end
    end else if (en && tail_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_v) begin
        out_lon   <= skid_lon;
        out_lat   <= skid_lat;
        pole_flag <= skid_pole;
      end else begin
        out_lon   <= tail_lon;
        out_lat   <= tail_lat;
        pole_flag <= tail_pole;
      end
    end else if (en && tail_v) begin
      skid_lon  <= tail_lon;
      skid_lat  <= tail_lat;
      skid_pole <= tail_pole;
    end
  end

  `EHT_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_v, out_valid)
  `EHT_ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && take, !skid_v && out_valid)
  `EHT_ASSERT_NEXT(a_out_empties, clk, rst, take && !skid_v && !tail_v, !out_valid)

endmodule

### rtl/eht_cordic_cell.sv
// one cordic micro-rotation stage, registered
module eht_cordic_cell (
  input  logic                         clk,
  input  logic                         en,
  input  eht_pkg::cordic_mode_t        mode,
  input  logic [eht_pkg::STAGE_W-1:0]  stage,
  input  eht_pkg::cordic_vec_t         d_in,
  output eht_pkg::cordic_vec_t         d_out
);
  import eht_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  a;
  logic                   ccw;

  always_comb begin
    dx  = d_in.y >>> stage;
    dy  = d_in.x >>> stage;
    a   = signed'({{(Z_W - ANGLE_W){1'b0}}, atan_turns(stage)});
    // rotate drives z to zero, vectoring drives y to zero
    ccw = (mode == CORDIC_ROTATE) ? !d_in.z[Z_W-1] : d_in.y[XY_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        d_out.x <= d_in.x - dx;
        d_out.y <= d_in.y + dy;
        d_out.z <= d_in.z - a;
      end else begin
        d_out.x <= d_in.x + dx;
        d_out.y <= d_in.y - dy;
        d_out.z <= d_in.z + a;
      end
    end
  end

endmodule

### rtl/eht_cordic_chain.sv
// row of cordic cells with range folding in front and sign fix behind
module eht_cordic_chain (
  input  logic                  clk,
  input  logic                  en,
  input  eht_pkg::cordic_mode_t mode,
  input  eht_pkg::cordic_vec_t  d_in,
  output eht_pkg::cordic_vec_t  d_out
);
  import eht_pkg::*;

  cordic_vec_t               pre;
  cordic_vec_t               pre_next;
  logic                      flip_pre;
  logic                      flip_pre_next;
  logic [CORDIC_STAGES-1:0]  flip_d;
  cordic_vec_t               link [CORDIC_STAGES+1];

  always_comb begin
    pre_next      = d_in;
    flip_pre_next = 1'b0;
    if (mode == CORDIC_ROTATE) begin
      // beyond a quarter turn: rotate by half a turn and negate afterwards
      if (d_in.z > QUARTER_TURN) begin
        pre_next.z    = d_in.z - HALF_TURN;
        flip_pre_next = 1'b1;
      end else if (d_in.z < -QUARTER_TURN) begin
        pre_next.z    = d_in.z + HALF_TURN;
        flip_pre_next = 1'b1;
      end
    end else begin
      if (d_in.x[XY_W-1]) begin
        pre_next.x = -d_in.x;
        pre_next.y = -d_in.y;
        pre_next.z = HALF_TURN;
      end else begin
        pre_next.z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre      <= pre_next;
      flip_pre <= flip_pre_next;
      flip_d   <= {flip_d[CORDIC_STAGES-2:0], flip_pre};
    end
  end

  assign link[0] = pre;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    eht_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .mode  (mode),
      .stage (STAGE_W'(g)),
      .d_in  (link[g]),
      .d_out (link[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.z <= link[CORDIC_STAGES].z;
      if (flip_d[CORDIC_STAGES-1]) begin
        d_out.x <= -link[CORDIC_STAGES].x;
        d_out.y <= -link[CORDIC_STAGES].y;
      end else begin
        d_out.x <= link[CORDIC_STAGES].x;
        d_out.y <= link[CORDIC_STAGES].y;
      end
    end
  end

endmodule

### rtl/eht_mulq.sv
// q30 product, rounded to nearest with ties away from zero, two stages
module eht_mulq (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [eht_pkg::AMP_W-1:0] a,
  input  logic signed [eht_pkg::AMP_W-1:0] b,
  output logic signed [eht_pkg::AMP_W-1:0] p
);
  import eht_pkg::*;

  logic signed [AMP_W-1:0]  mag_a;
  logic signed [AMP_W-1:0]  mag_b;
  logic [2*MAG_W-1:0]       prod;
  logic                     neg;
  logic [2*MAG_W-1:0]       prod_rnd;
  logic signed [AMP_W-1:0]  rnd;

  always_comb begin
    mag_a    = a[AMP_W-1] ? -a : a;
    mag_b    = b[AMP_W-1] ? -b : b;
    prod_rnd = prod + (2*MAG_W)'(64'd1 << 29);
    rnd      = signed'(prod_rnd[30 +: AMP_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= mag_a[MAG_W-1:0] * mag_b[MAG_W-1:0];
      neg  <= a[AMP_W-1] ^ b[AMP_W-1];
      p    <= neg ? -rnd : rnd;
    end
  end

endmodule
